### hw/rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the servo pulse throttle decoder
// Holds the controller state encoding, the command and status bundles
// between controller and datapath, and the fixed constants of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  // Input and result item widths on the stream ports.
  localparam int unsigned IN_W  = 24;
  localparam int unsigned OUT_W = 48;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BIDIR   = 2'd0;
  localparam logic [1:0] CFG_NEUTRAL = 2'd1;
  localparam logic [1:0] CFG_STEP    = 2'd2;
  localparam logic [1:0] CFG_ASYM    = 2'd3;

  // Calibration pulse counts.
  localparam logic [6:0] HIGH_CAL_PULSES = 7'd50;
  localparam logic [6:0] LOW_CAL_PULSES  = 7'd75;

  // Quotient bits produced by the divider, one per cycle.
  localparam logic [3:0] DIV_STEPS = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_MAP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;      // capture the accepted item
    logic prep;      // calibration update and mapping setup
    logic mul;       // scale the clamped offset
    logic div_step;  // one restoring division step
    logic map;       // add output offset, store raw throttle
    logic fin;       // slew and load the result register
  } spt_cmd_t;

  typedef struct packed {
    logic need_map;  // item is valid and not taken by calibration
  } spt_status_t;

endpackage

`default_nettype wire

### hw/rtl/servo_pulse_throttle_decoder_core.sv
// ----------------------------------------------------------------------------
// servo_pulse_throttle_decoder_core: RC servo pulse to throttle decoder
// Maps measured pulse widths to a slew-limited throttle, with endpoint
// calibration that averages the high and then the low stick position.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake                 Payload
//   in_      slave      in_tvalid / in_tready     one pulse item, 24-bit tdata
//   out_     master     out_tvalid / out_tready   one result item, 48-bit tdata
//   cfg_     write      cfg_we                    cfg_index, 11-bit cfg_data
//
// A mapped pulse goes from acceptance to a registered result through one
// capture, one calibration and setup, one multiply, eleven bit-serial divider
// steps, one map and one write. Invalid pulses and pulses used by calibration
// skip the multiply, divide and map steps. Reset is synchronous and restores
// the configuration and calibration defaults. A stalled result holds the next
// item in its write cycle; one item may be accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pulse_throttle_decoder_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // [15:0] pulse_width, [16] spinning_forward, [17] calibrate_request
  input  wire logic [spt_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // [10:0] throttle, [21:11] raw_throttle, [22] pulse_valid, [23] calibrating,
  // [24] high_captured, [25] calibration_done, [33:26] high_code,
  // [41:34] low_code
  output logic [spt_pkg::OUT_W-1:0]      out_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [10:0]               cfg_data
);
  import spt_pkg::*;

  spt_cmd_t    cmd;
  spt_status_t status;

  spt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  spt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

### hw/rtl/spt_dp.sv
// ----------------------------------------------------------------------------
// spt_dp: datapath of the servo pulse throttle decoder
// Configuration registers, calibration state, the range mapping with a
// shared multiplier and a bit-serial divider, the throttle slew limiter and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire spt_pkg::spt_cmd_t         cmd,
  output spt_pkg::spt_status_t           status,
  input  wire logic [spt_pkg::IN_W-1:0]  in_data,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [10:0]               cfg_data,
  output logic [spt_pkg::OUT_W-1:0]      out_data
);
  import spt_pkg::*;

  function automatic logic [11:0] avg8(input logic [11:0] t, input logic [15:0] w);
    logic [16:0] s;
    s = ({2'b0, t, 3'b0} - {5'b0, t}) + {1'b0, w};
    return s[14:3];
  endfunction

  function automatic logic [7:0] byte_code(input logic [11:0] v, input logic [11:0] base);
    logic [11:0] d;
    d = v - base;
    if (v <= base) begin
      return 8'd0;
    end
    if (d[11:1] > 11'd255) begin
      return 8'd255;
    end
    return d[8:1];
  endfunction

  // Configuration.
  logic        bidir_r, asym_r;
  logic [10:0] neutral_r, max_step_r;

  // Captured item.
  logic [15:0] width_r;
  logic        fwd_r, req_r;

  // Decoder state.
  logic [11:0] low_thr_r, high_thr_r, last_hi_r;
  logic [6:0]  hi_cnt_r, lo_cnt_r;
  logic        hi_set_r, cal_act_r;
  logic [10:0] mapped_r, out_thr_r;

  // Per-item flags.
  logic        valid_r, hi_cap_r, done_r;

  // Mapping and divider.
  logic [11:0] xoff_r;
  logic [10:0] range_r, olo_r;
  logic        degen_r, uni_r;
  logic [22:0] rem_r;
  logic [21:0] dsh_r;
  logic [10:0] quo_r;

  logic [OUT_W-1:0] out_data_r;

  // Calibration next values.
  logic        valid_w, act_eff;
  logic [11:0] low_thr_nxt, high_thr_nxt, last_hi_nxt, last_v, hi_gap, ht_avg, lt_avg;
  logic [6:0]  hi_cnt_nxt, lo_cnt_nxt;
  logic        hi_set_nxt, cal_act_nxt, hi_cap_nxt, done_nxt;

  // Mapping setup.
  logic [11:0] x;
  logic [12:0] lo, hi, xc;
  logic [10:0] range_nxt, olo_nxt;
  logic        uni_nxt;
  logic [12:0] xoff_w, dv_w;

  // Divider step, map and slew.
  logic [22:0] sub_w;
  logic [10:0] map_w;
  logic [10:0] up, down;
  logic [11:0] rise, fall;
  logic [10:0] out_thr_nxt;

  assign valid_w = (width_r > 16'd800) && (width_r < 16'd2200);
  // A request takes effect before the pulse is looked at.
  assign act_eff = cal_act_r | (req_r & ~hi_set_r);
  assign status.need_map = valid_w & ~act_eff;

  always_comb begin
    low_thr_nxt  = low_thr_r;
    high_thr_nxt = high_thr_r;
    last_hi_nxt  = last_hi_r;
    hi_cnt_nxt   = hi_cnt_r;
    lo_cnt_nxt   = lo_cnt_r;
    hi_set_nxt   = hi_set_r;
    cal_act_nxt  = act_eff;
    hi_cap_nxt   = 1'b0;
    done_nxt     = 1'b0;
    last_v       = (hi_cnt_r == 7'd0) ? width_r[11:0] : last_hi_r;
    hi_gap       = (last_v > high_thr_r) ? (last_v - high_thr_r) : (high_thr_r - last_v);
    ht_avg       = avg8(high_thr_r, width_r);
    lt_avg       = avg8(low_thr_r, width_r);
    if (valid_w && act_eff) begin
      if (!hi_set_r) begin
        hi_cnt_nxt = (hi_cnt_r == 7'd127) ? hi_cnt_r : hi_cnt_r + 7'd1;
        if (hi_gap > 12'd50) begin
          cal_act_nxt = 1'b0;
        end else begin
          high_thr_nxt = ht_avg;
          if (hi_cnt_nxt > HIGH_CAL_PULSES) begin
            high_thr_nxt = ht_avg - 12'd25;
            hi_set_nxt   = 1'b1;
            hi_cap_nxt   = 1'b1;
          end
        end
        last_hi_nxt = high_thr_nxt;
      end
      // The low phase runs in the same item that fixes the high endpoint.
      if (hi_set_nxt) begin
        if (width_r < 16'd1250) begin
          lo_cnt_nxt  = (lo_cnt_r == 7'd127) ? lo_cnt_r : lo_cnt_r + 7'd1;
          low_thr_nxt = lt_avg;
        end
        if (lo_cnt_nxt > LOW_CAL_PULSES) begin
          low_thr_nxt = low_thr_nxt + 12'd25;
          cal_act_nxt = 1'b0;
          lo_cnt_nxt  = 7'd0;
          done_nxt    = 1'b1;
        end
      end
    end
  end

  always_comb begin
    x = width_r[11:0];
    if (bidir_r && ({4'b0, x} <= {5'b0, neutral_r})) begin
      lo        = {1'b0, low_thr_r};
      hi        = {2'b0, neutral_r};
      olo_nxt   = 11'd0;
      range_nxt = 11'd1000;
      uni_nxt   = 1'b0;
    end else if (bidir_r) begin
      lo        = {2'b0, neutral_r} + 13'd1;
      hi        = {1'b0, high_thr_r};
      olo_nxt   = 11'd1001;
      range_nxt = 11'd999;
      uni_nxt   = 1'b0;
    end else begin
      lo        = {1'b0, low_thr_r};
      hi        = {1'b0, high_thr_r};
      olo_nxt   = 11'd47;
      range_nxt = 11'd2000;
      uni_nxt   = 1'b1;
    end
    if ({1'b0, x} < lo) begin
      xc = lo;
    end else if ({1'b0, x} > hi) begin
      xc = hi;
    end else begin
      xc = {1'b0, x};
    end
    xoff_w = xc - lo;
    dv_w   = hi - lo;
  end

  assign sub_w = rem_r - {1'b0, dsh_r};

  always_comb begin
    map_w = degen_r ? olo_r : quo_r + olo_r;
    if (uni_r && map_w == 11'd47) begin
      map_w = 11'd0;
    end
  end

  always_comb begin
    up   = max_step_r;
    down = max_step_r;
    if (asym_r) begin
      if (fwd_r) begin
        down = {2'b0, max_step_r[10:2]};
      end else begin
        up = {2'b0, max_step_r[10:2]};
      end
    end
    rise = {1'b0, mapped_r} - {1'b0, out_thr_r};
    fall = {1'b0, out_thr_r} - {1'b0, mapped_r};
    if ($signed(rise) > $signed({1'b0, up})) begin
      out_thr_nxt = out_thr_r + up;
    end else if ($signed(fall) > $signed({1'b0, down})) begin
      out_thr_nxt = out_thr_r - down;
    end else begin
      out_thr_nxt = mapped_r;
    end
  end

  // Configuration and decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bidir_r    <= 1'b0;
      neutral_r  <= 11'd1500;
      max_step_r <= 11'd200;
      asym_r     <= 1'b0;
      low_thr_r  <= 12'd1100;
      high_thr_r <= 12'd1900;
      last_hi_r  <= 12'd0;
      hi_cnt_r   <= 7'd0;
      lo_cnt_r   <= 7'd0;
      hi_set_r   <= 1'b0;
      cal_act_r  <= 1'b0;
      mapped_r   <= 11'd0;
      out_thr_r  <= 11'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIDIR:   bidir_r    <= cfg_data[0];
          CFG_NEUTRAL: neutral_r  <= cfg_data;
          CFG_STEP:    max_step_r <= cfg_data;
          CFG_ASYM:    asym_r     <= cfg_data[0];
          default:     bidir_r    <= bidir_r;
        endcase
      end
      if (cmd.prep) begin
        low_thr_r  <= low_thr_nxt;
        high_thr_r <= high_thr_nxt;
        last_hi_r  <= last_hi_nxt;
        hi_cnt_r   <= hi_cnt_nxt;
        lo_cnt_r   <= lo_cnt_nxt;
        hi_set_r   <= hi_set_nxt;
        cal_act_r  <= cal_act_nxt;
      end
      if (cmd.map) begin
        mapped_r <= map_w;
      end
      if (cmd.fin) begin
        out_thr_r <= out_thr_nxt;
      end
    end
  end

  // Item capture, mapping operands, divider and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      width_r <= in_data[15:0];
      fwd_r   <= in_data[16];
      req_r   <= in_data[17];
    end
    if (cmd.prep) begin
      valid_r  <= valid_w;
      hi_cap_r <= hi_cap_nxt;
      done_r   <= done_nxt;
      xoff_r   <= xoff_w[11:0];
      range_r  <= range_nxt;
      olo_r    <= olo_nxt;
      uni_r    <= uni_nxt;
      degen_r  <= (hi <= lo);
      dsh_r    <= {dv_w[11:0], 10'b0};
    end
    if (cmd.mul) begin
      rem_r <= 23'(xoff_r * range_r);
      quo_r <= 11'd0;
    end
    if (cmd.div_step) begin
      if ({1'b0, dsh_r} <= rem_r) begin
        rem_r <= sub_w;
        quo_r <= {quo_r[9:0], 1'b1};
      end else begin
        quo_r <= {quo_r[9:0], 1'b0};
      end
      dsh_r <= {1'b0, dsh_r[21:1]};
    end
    if (cmd.fin) begin
      out_data_r <= {6'b0,
                     byte_code(low_thr_r, 12'd750),
                     byte_code(high_thr_r, 12'd1750),
                     done_r, hi_cap_r, cal_act_r, valid_r,
                     mapped_r, out_thr_nxt};
    end
  end

  assign out_data = out_data_r;

  a_cap_sets_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prep && hi_cap_nxt |=> hi_set_r)
    else $error("high capture without endpoint set");

  a_done_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prep && done_nxt |=> !cal_act_r && lo_cnt_r == 7'd0)
    else $error("calibration done left calibration active");

  a_endpoint_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    hi_set_r |=> hi_set_r)
    else $error("high endpoint flag cleared");

endmodule

`default_nettype wire

### hw/rtl/spt_ctrl.sv
// ----------------------------------------------------------------------------
// spt_ctrl: controller of the servo pulse throttle decoder
// Sequences capture, calibration, multiply, divide, map and result write,
// and owns the input ready and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire spt_pkg::spt_status_t status,
  output spt_pkg::spt_cmd_t         cmd
);
  import spt_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = status.need_map ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = DIV_STEPS - 4'd1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == 4'd0) begin
          state_nxt = ST_MAP;
        end else begin
          step_nxt = step_r - 4'd1;
        end
      end
      ST_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Wait here until the result register is free.
        if (!out_valid_r || out_tready) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.fin | (out_valid_r & ~out_tready);
  end

  assign out_tvalid = out_valid_r;

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_PREP)
    else $error("accepted item not prepared");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && step_r == 4'd0 |=> state_r == ST_MAP)
    else $error("divider did not finish on the last step");

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("result written without valid");

endmodule

`default_nettype wire
